/* rtl/core/crr_pkg.sv */
// Shared constants and codes for the chained range remap block.
// Depends on nothing; the files that use it refer to it by scoped names.
`default_nettype none

package crr_pkg;

  // Fixed field widths of the item and result beats
  localparam int FIELD_W     = 32;
  localparam int STAGE_SEL_W = 3;
  localparam int ENTRY_SEL_W = 6;
  localparam int HIT_W       = 7;

  // Item action codes
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_XLATE = 1'b1
  } action_t;

endpackage

`default_nettype wire

/* rtl/core/crr_if.sv */
// Valid/ready channel interfaces for the item and result beats.
// Depends on crr_pkg for the field widths.
`default_nettype none

interface crr_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [crr_pkg::STAGE_SEL_W-1:0]   stage_sel;
  logic [crr_pkg::ENTRY_SEL_W-1:0]   entry_sel;
  logic [crr_pkg::FIELD_W-1:0]       dest_base;
  logic [crr_pkg::FIELD_W-1:0]       src_base;
  logic [crr_pkg::FIELD_W-1:0]       span;
  logic                              entry_valid;
  logic [crr_pkg::FIELD_W-1:0]       query_value;

  modport source (
    output valid, action, stage_sel, entry_sel, dest_base, src_base, span,
           entry_valid, query_value,
    input  ready
  );
  modport sink (
    input  valid, action, stage_sel, entry_sel, dest_base, src_base, span,
           entry_valid, query_value,
    output ready
  );
endinterface

interface crr_out_if;
  logic                          valid;
  logic                          ready;
  logic [crr_pkg::FIELD_W-1:0]   mapped_value;
  logic [crr_pkg::HIT_W-1:0]     hit_mask;

  modport source (output valid, mapped_value, hit_mask, input ready);
  modport sink   (input valid, mapped_value, hit_mask, output ready);
endinterface

`default_nettype wire

/* rtl/core/crr_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module crr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/crr_match_unit.sv */
// Shared range compare and translate unit, used once per entry read.
// Entry word layout: valid, destination, start, span (MSB to LSB).
`default_nettype none

module crr_match_unit #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic [VALUE_BITS-1:0]   value,
  input  wire logic [3*VALUE_BITS:0]   entry,
  output logic                         hit,
  output logic [VALUE_BITS-1:0]        result
);

  logic                  ent_vld;
  logic [VALUE_BITS-1:0] ent_dest;
  logic [VALUE_BITS-1:0] ent_start;
  logic [VALUE_BITS-1:0] ent_span;
  logic [VALUE_BITS-1:0] offset;

  // Unpack the entry word
  assign ent_vld   = entry[3*VALUE_BITS];
  assign ent_dest  = entry[3*VALUE_BITS-1:2*VALUE_BITS];
  assign ent_start = entry[2*VALUE_BITS-1:VALUE_BITS];
  assign ent_span  = entry[VALUE_BITS-1:0];

  // Offset into the range; a zero span can never satisfy offset < span
  assign offset = value - ent_start;
  assign hit    = ent_vld && (value >= ent_start) && (offset < ent_span);
  assign result = ent_dest + offset;

endmodule

`default_nettype wire

/* rtl/core/chained_range_remap.sv */
// Chained range remap: NUM_STAGES translation stages of range entries.
//
// Input channel in_chan takes one beat per item. action ACT_WRITE loads or
// invalidates one entry (stage_sel, entry_sel); writes aimed past the table
// are dropped. action ACT_XLATE passes query_value through every stage: in
// each stage the lowest-indexed valid entry whose source range holds the
// value maps it to dest_base + (value - src_base). Every item yields one
// result beat on out_chan; writes return zero mapped_value and hit_mask.
//
// Flow: an accepted write goes to ST_FIN and from there into the output
// register. A translate reads the entry table one word per cycle through the
// single RAM read port into the one compare unit; a hit ends its stage early
// at the cost of one dead read. One item is in work at a time; in_chan.ready
// is high only while the sequencer idles.
//
// Reset: rst_n clears the control state and starts a clearing pass that
// marks all NUM_STAGES*ENTRIES_PER_STAGE entries invalid; no item is taken
// until it ends. The result sits in an output register; while the
// receiver stalls a new item may still be accepted and worked, and its result
// waits until the register frees.
`default_nettype none

module chained_range_remap #(
  parameter int NUM_STAGES        = 7,
  parameter int ENTRIES_PER_STAGE = 64,
  parameter int VALUE_BITS        = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  crr_in_if.sink           in_chan,
  crr_out_if.source        out_chan
);

  localparam int TOTAL = NUM_STAGES * ENTRIES_PER_STAGE;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int EW    = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
  localparam int WW    = 3 * VALUE_BITS + 1;

  localparam logic [AW-1:0] LAST_ADDR  = AW'(TOTAL - 1);
  localparam logic [SW-1:0] LAST_STAGE = SW'(NUM_STAGES - 1);
  localparam logic [EW-1:0] LAST_ENTRY = EW'(ENTRIES_PER_STAGE - 1);

  typedef enum logic [1:0] {
    ST_CLR,
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t                       state_r,     state_nxt;
  logic [AW-1:0]                clr_addr_r,  clr_addr_nxt;
  logic [VALUE_BITS-1:0]        val_r,       val_nxt;
  logic [crr_pkg::HIT_W-1:0]    mask_r,      mask_nxt;
  logic [AW-1:0]                is_addr_r,   is_addr_nxt;
  logic [SW-1:0]                is_stg_r,    is_stg_nxt;
  logic [EW-1:0]                is_ent_r,    is_ent_nxt;
  logic                         issuing_r,   issuing_nxt;
  logic                         ev_vld_r,    ev_vld_nxt;
  logic [SW-1:0]                ev_stg_r,    ev_stg_nxt;
  logic                         ev_final_r,  ev_final_nxt;
  logic                         out_vld_r,   out_vld_nxt;
  logic [crr_pkg::FIELD_W-1:0]  out_val_r,   out_val_nxt;
  logic [crr_pkg::HIT_W-1:0]    out_mask_r,  out_mask_nxt;

  logic                         in_acc;
  logic                         is_write;
  logic                         wr_in_range;
  logic [AW-1:0]                wr_addr;
  logic                         out_free;
  logic                         is_final;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [WW-1:0]                ram_wdata;
  logic [WW-1:0]                ram_rdata;

  logic                         mu_hit;
  logic [VALUE_BITS-1:0]        mu_res;

  // Handshakes
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign is_write      = (in_chan.action == crr_pkg::ACT_WRITE);
  assign out_free      = !out_vld_r || out_chan.ready;

  assign out_chan.valid        = out_vld_r;
  assign out_chan.mapped_value = out_val_r;
  assign out_chan.hit_mask     = out_mask_r;

  // Entry write address and range check
  assign wr_in_range = (32'(in_chan.stage_sel) < NUM_STAGES) &&
                       (32'(in_chan.entry_sel) < ENTRIES_PER_STAGE);
  assign wr_addr     = AW'(32'(in_chan.stage_sel) * ENTRIES_PER_STAGE +
                           32'(in_chan.entry_sel));

  // Table RAM: clearing pass or entry write; reads follow the issue pointer
  assign ram_we    = (state_r == ST_CLR) || (in_acc && is_write && wr_in_range);
  assign ram_waddr = (state_r == ST_CLR) ? clr_addr_r : wr_addr;
  assign ram_wdata = (state_r == ST_CLR) ? '0 :
                     {in_chan.entry_valid, VALUE_BITS'(in_chan.dest_base),
                      VALUE_BITS'(in_chan.src_base), VALUE_BITS'(in_chan.span)};

  crr_ram #(
    .WIDTH (WW),
    .DEPTH (TOTAL)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (is_addr_r),
    .rdata (ram_rdata)
  );

  crr_match_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_match (
    .value  (val_r),
    .entry  (ram_rdata),
    .hit    (mu_hit),
    .result (mu_res)
  );

  assign is_final = (is_stg_r == LAST_STAGE) && (is_ent_r == LAST_ENTRY);

  // Sequencer next state
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    val_nxt      = val_r;
    mask_nxt     = mask_r;
    is_addr_nxt  = is_addr_r;
    is_stg_nxt   = is_stg_r;
    is_ent_nxt   = is_ent_r;
    issuing_nxt  = issuing_r;
    ev_vld_nxt   = 1'b0;
    ev_stg_nxt   = ev_stg_r;
    ev_final_nxt = ev_final_r;
    out_vld_nxt  = out_vld_r;
    out_val_nxt  = out_val_r;
    out_mask_nxt = out_mask_r;

    // Drop the result once the receiver takes it
    if (out_vld_r && out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          val_nxt  = '0;
          mask_nxt = '0;
          if (is_write) begin
            state_nxt = ST_FIN;
          end else begin
            val_nxt     = VALUE_BITS'(in_chan.query_value);
            is_addr_nxt = '0;
            is_stg_nxt  = '0;
            is_ent_nxt  = '0;
            issuing_nxt = 1'b1;
            state_nxt   = ST_RUN;
          end
        end
      end

      ST_RUN: begin
        if (ev_vld_r && mu_hit) begin
          // Take the mapping, skip the rest of this stage
          val_nxt = mu_res;
          for (int i = 0; i < crr_pkg::HIT_W; i++) begin
            if (32'(ev_stg_r) == i) begin
              mask_nxt[i] = 1'b1;
            end
          end
          if (ev_stg_r == LAST_STAGE) begin
            issuing_nxt = 1'b0;
            state_nxt   = ST_FIN;
          end else begin
            is_stg_nxt  = ev_stg_r + SW'(1);
            is_ent_nxt  = '0;
            is_addr_nxt = AW'((32'(ev_stg_r) + 1) * ENTRIES_PER_STAGE);
            issuing_nxt = 1'b1;
          end
        end else begin
          if (ev_vld_r && ev_final_r) begin
            state_nxt = ST_FIN;
          end
          // Issue the next entry read
          if (issuing_r) begin
            ev_vld_nxt   = 1'b1;
            ev_stg_nxt   = is_stg_r;
            ev_final_nxt = is_final;
            is_addr_nxt  = is_addr_r + AW'(1);
            if (is_ent_r == LAST_ENTRY) begin
              is_ent_nxt = '0;
              is_stg_nxt = is_stg_r + SW'(1);
            end else begin
              is_ent_nxt = is_ent_r + EW'(1);
            end
            if (is_final) begin
              issuing_nxt = 1'b0;
            end
          end
        end
      end

      ST_FIN: begin
        // Hold until the output register frees
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_val_nxt  = crr_pkg::FIELD_W'(val_r);
          out_mask_nxt = mask_r;
          state_nxt    = ST_IDLE;
        end
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_addr_r <= '0;
      issuing_r  <= 1'b0;
      ev_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      issuing_r  <= issuing_nxt;
      ev_vld_r   <= ev_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      val_r      <= val_nxt;
      mask_r     <= mask_nxt;
      is_addr_r  <= is_addr_nxt;
      is_stg_r   <= is_stg_nxt;
      is_ent_r   <= is_ent_nxt;
      ev_stg_r   <= ev_stg_nxt;
      ev_final_r <= ev_final_nxt;
      out_val_r  <= out_val_nxt;
      out_mask_r <= out_mask_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/crr_checker.sv */
// Port-level assertions for chained_range_remap, attached by bind.
// Depends on crr_pkg for the result field widths.
`default_nettype none

module crr_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [crr_pkg::FIELD_W-1:0]   out_mapped_value,
  input wire logic [crr_pkg::HIT_W-1:0]     out_hit_mask
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_mapped_value) && $stable(out_hit_mask))
    else $error("result beat changed while stalled");

  // One item in work at a time: no accept on the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an accepted beat");

  // A new result only comes out of a busy sequencer
  a_res_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind chained_range_remap crr_checker u_crr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_mapped_value (out_chan.mapped_value),
  .out_hit_mask     (out_chan.hit_mask)
);

`default_nettype wire

/* test/crr_remap_checker.sv */
// Result checker for the chained range remap block: watches both channels,
// keeps its own copy of the entry tables and compares every result beat.
// Depends on crr_pkg and the channel interfaces in crr_if.sv.
`timescale 1ns / 1ps

module crr_remap_checker #(
  parameter int NUM_STAGES        = 7,
  parameter int ENTRIES_PER_STAGE = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  crr_in_if         in_mon,
  crr_out_if        out_mon,
  output int        mismatch_cnt,
  output int        pending_cnt,
  output int        xlate_cnt,
  output int        hit_cnt
);

  localparam int TABLE_DEPTH = NUM_STAGES * ENTRIES_PER_STAGE;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [crr_pkg::FIELD_W-1:0] mapped_value;
    logic [crr_pkg::HIT_W-1:0]   hit_mask;
  } remap_result_t;

  // Shadow copy of the entry tables
  logic [crr_pkg::FIELD_W-1:0] dest_tab  [TABLE_DEPTH];
  logic [crr_pkg::FIELD_W-1:0] start_tab [TABLE_DEPTH];
  logic [crr_pkg::FIELD_W-1:0] span_tab  [TABLE_DEPTH];
  bit                          valid_tab [TABLE_DEPTH];

  remap_result_t expected_results[$];
  int            result_idx;

  // Walk one value through every stage; lowest matching entry wins
  function automatic remap_result_t walk_stages(input logic [crr_pkg::FIELD_W-1:0] value);
    remap_result_t               res;
    logic [crr_pkg::FIELD_W-1:0] v;
    int                          k;
    bit                          hit;
    v = value;
    res.hit_mask = '0;
    for (int s = 0; s < NUM_STAGES; s++) begin
      hit = 1'b0;
      for (int e = 0; e < ENTRIES_PER_STAGE && !hit; e++) begin
        k = s * ENTRIES_PER_STAGE + e;
        if (valid_tab[k] && span_tab[k] != '0 && v >= start_tab[k] &&
            (v - start_tab[k]) < span_tab[k]) begin
          v   = dest_tab[k] + (v - start_tab[k]);
          hit = 1'b1;
        end
      end
      if (hit) res.hit_mask[s] = 1'b1;
    end
    res.mapped_value = v;
    return res;
  endfunction

  always @(posedge clk) begin
    remap_result_t exp_res;
    int            k;
    if (!rst_n) begin
      foreach (valid_tab[i]) valid_tab[i] = 1'b0;
      expected_results.delete();
      result_idx   = 0;
      mismatch_cnt <= 0;
      pending_cnt  <= 0;
      xlate_cnt    <= 0;
      hit_cnt      <= 0;
    end else begin
      // Compare a result beat against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("[%0t] result %0d: unexpected beat, mapped %h hits %b", $realtime,
                     result_idx, out_mon.mapped_value, out_mon.hit_mask);
          mismatch_cnt <= mismatch_cnt + 1;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_mon.mapped_value !== exp_res.mapped_value ||
              out_mon.hit_mask !== exp_res.hit_mask) begin
            if (mismatch_cnt < MAX_REPORTS)
              $display("[%0t] result %0d: expected mapped %h hits %b, got mapped %h hits %b",
                       $realtime, result_idx, exp_res.mapped_value, exp_res.hit_mask,
                       out_mon.mapped_value, out_mon.hit_mask);
            mismatch_cnt <= mismatch_cnt + 1;
          end
        end
        result_idx++;
      end
      // Predict the result of an accepted item beat
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == crr_pkg::ACT_XLATE) begin
          exp_res = walk_stages(in_mon.query_value);
          xlate_cnt <= xlate_cnt + 1;
          if (exp_res.hit_mask != '0) hit_cnt <= hit_cnt + 1;
        end else begin
          // Drop writes aimed past the table; the result is zero either way
          if (in_mon.stage_sel < NUM_STAGES && in_mon.entry_sel < ENTRIES_PER_STAGE) begin
            k = in_mon.stage_sel * ENTRIES_PER_STAGE + in_mon.entry_sel;
            dest_tab[k]  = in_mon.dest_base;
            start_tab[k] = in_mon.src_base;
            span_tab[k]  = in_mon.span;
            valid_tab[k] = in_mon.entry_valid;
          end
          exp_res.mapped_value = '0;
          exp_res.hit_mask     = '0;
        end
        // Queue the expectation behind the older ones
        expected_results.insert(expected_results.size(), exp_res);
      end
      pending_cnt <= expected_results.size();
    end
  end

endmodule

/* test/tb.sv */
// Testbench top for the chained range remap block: drives item beats,
// toggles receiver back-pressure and reports the verdict.
// Depends on crr_pkg, crr_if.sv, the block itself and crr_remap_checker.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_STAGES        = 7;
  localparam int ENTRIES_PER_STAGE = 64;
  localparam int RAND_ITEMS        = 928;
  localparam int HOLD_CYCLES       = 1500;
  localparam int DRAIN_CYCLES      = 500;
  localparam int CYCLE_LIMIT       = 2000000;

  typedef struct {
    crr_pkg::action_t                action;
    logic [crr_pkg::STAGE_SEL_W-1:0] stage_sel;
    logic [crr_pkg::ENTRY_SEL_W-1:0] entry_sel;
    logic [crr_pkg::FIELD_W-1:0]     dest_base;
    logic [crr_pkg::FIELD_W-1:0]     src_base;
    logic [crr_pkg::FIELD_W-1:0]     span;
    logic                            entry_valid;
    logic [crr_pkg::FIELD_W-1:0]     query_value;
  } remap_item_t;

  logic clk;
  logic rst_n;
  bit   rx_hold;
  int   idle_pct;
  int   stall_pct;
  int   sent_cnt;
  int   dropped_writes;
  int   cycle_cnt;
  int   mismatch_cnt;
  int   pending_cnt;
  int   xlate_cnt;
  int   hit_cnt;

  logic [crr_pkg::FIELD_W-1:0] recent_src [8] = '{default: '0};
  int                          recent_idx;

  int idle_by_phase  [4] = '{0, 60, 0, 32};
  int stall_by_phase [4] = '{0, 0, 60, 32};

  crr_in_if  in_chan ();
  crr_out_if out_chan ();

  chained_range_remap #(
    .NUM_STAGES        (NUM_STAGES),
    .ENTRIES_PER_STAGE (ENTRIES_PER_STAGE),
    .VALUE_BITS        (crr_pkg::FIELD_W)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  crr_remap_checker #(
    .NUM_STAGES        (NUM_STAGES),
    .ENTRIES_PER_STAGE (ENTRIES_PER_STAGE)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt),
    .xlate_cnt    (xlate_cnt),
    .hit_cnt      (hit_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n || rx_hold) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Hold the receiver off long enough for the block to fill and stall its input
  initial begin
    rx_hold <= 1'b0;
    wait (sent_cnt >= 80);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic remap_item_t mk_write(input int stg, input int ent,
                                           input logic [crr_pkg::FIELD_W-1:0] dst,
                                           input logic [crr_pkg::FIELD_W-1:0] src,
                                           input logic [crr_pkg::FIELD_W-1:0] len,
                                           input bit vld);
    remap_item_t it;
    it.action      = crr_pkg::ACT_WRITE;
    it.stage_sel   = crr_pkg::STAGE_SEL_W'(stg);
    it.entry_sel   = crr_pkg::ENTRY_SEL_W'(ent);
    it.dest_base   = dst;
    it.src_base    = src;
    it.span        = len;
    it.entry_valid = vld;
    it.query_value = $urandom;
    return it;
  endfunction

  function automatic remap_item_t mk_query(input logic [crr_pkg::FIELD_W-1:0] value);
    remap_item_t it;
    it.action      = crr_pkg::ACT_XLATE;
    it.stage_sel   = crr_pkg::STAGE_SEL_W'($urandom);
    it.entry_sel   = crr_pkg::ENTRY_SEL_W'($urandom);
    it.dest_base   = $urandom;
    it.src_base    = $urandom;
    it.span        = $urandom;
    it.entry_valid = 1'($urandom_range(1));
    it.query_value = value;
    return it;
  endfunction

  // Mostly small ranges in a narrow window so that stages chain and overlap
  function automatic remap_item_t rand_item();
    remap_item_t                 it;
    int                          shape;
    int                          stg;
    int                          ent;
    logic [crr_pkg::FIELD_W-1:0] dst;
    logic [crr_pkg::FIELD_W-1:0] src;
    logic [crr_pkg::FIELD_W-1:0] len;
    logic [crr_pkg::FIELD_W-1:0] q;
    if ($urandom_range(99) < 35) begin
      stg   = ($urandom_range(99) < 5) ? 7 : $urandom_range(NUM_STAGES - 1);
      ent   = ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(63);
      shape = $urandom_range(99);
      if (shape < 70) begin
        dst = $urandom_range(2047);
        src = $urandom_range(2047);
        len = $urandom_range(256, 1);
      end else if (shape < 80) begin
        dst = $urandom;
        src = $urandom;
        len = $urandom;
      end else if (shape < 85) begin
        dst = $urandom_range(2047);
        src = $urandom_range(2047);
        len = '0;
      end else if (shape < 92) begin
        dst = $urandom;
        src = 32'hFFFF_FFFF - $urandom_range(255);
        len = $urandom;
      end else begin
        dst = 32'hFFFF_FFFF - $urandom_range(255);
        src = $urandom_range(2047);
        len = $urandom_range(512, 1);
      end
      recent_src[recent_idx] = src;
      recent_idx = (recent_idx + 1) % 8;
      it = mk_write(stg, ent, dst, src, len, $urandom_range(99) < 85);
    end else begin
      shape = $urandom_range(99);
      if (shape < 45)      q = $urandom_range(2047);
      else if (shape < 70) q = recent_src[$urandom_range(7)] + $urandom_range(15);
      else if (shape < 80) q = 32'hFFFF_FFFF - $urandom_range(255);
      else if (shape < 85) q = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      else                 q = $urandom;
      it = mk_query(q);
    end
    return it;
  endfunction

  // Offer one item beat and hold it until accepted
  task automatic send_item(input remap_item_t it);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.action      <= it.action;
    in_chan.stage_sel   <= it.stage_sel;
    in_chan.entry_sel   <= it.entry_sel;
    in_chan.dest_base   <= it.dest_base;
    in_chan.src_base    <= it.src_base;
    in_chan.span        <= it.span;
    in_chan.entry_valid <= it.entry_valid;
    in_chan.query_value <= it.query_value;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent_cnt++;
    if (it.action == crr_pkg::ACT_WRITE && it.stage_sel >= NUM_STAGES) dropped_writes++;
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.action      <= crr_pkg::ACT_WRITE;
    in_chan.stage_sel   <= '0;
    in_chan.entry_sel   <= '0;
    in_chan.dest_base   <= '0;
    in_chan.src_base    <= '0;
    in_chan.span        <= '0;
    in_chan.entry_valid <= 1'b0;
    in_chan.query_value <= '0;
    idle_pct            = 0;
    stall_pct           = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: values pass untouched
    send_item(mk_query(32'h0));
    send_item(mk_query(32'hFFFF_FFFF));
    // Range edges and priority of the lower entry
    send_item(mk_write(0, 0, 32'd1000, 32'd0, 32'd10, 1'b1));
    send_item(mk_query(32'd5));
    send_item(mk_query(32'd10));
    send_item(mk_write(0, 1, 32'd2000, 32'd0, 32'd100, 1'b1));
    send_item(mk_query(32'd9));
    send_item(mk_query(32'd50));
    // Chain through later stages, destination wrapping past the top
    send_item(mk_write(1, 63, 32'hFFFF_FFF0, 32'd1000, 32'd100, 1'b1));
    send_item(mk_query(32'd5));
    send_item(mk_write(2, 0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd16, 1'b1));
    send_item(mk_query(32'd5));
    // Zero span never matches
    send_item(mk_write(3, 0, 32'd77, 32'd0, 32'd0, 1'b1));
    send_item(mk_query(32'd4));
    // Range running past the top ends there
    send_item(mk_write(4, 5, 32'h0, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1));
    send_item(mk_query(32'hFFFF_FF80));
    // Invalidate the priority entry, keep its data
    send_item(mk_write(0, 0, 32'd1000, 32'd0, 32'd10, 1'b0));
    send_item(mk_query(32'd5));
    // Stage past the table is dropped
    send_item(mk_write(7, 0, 32'd123, 32'd0, 32'hFFFF_FFFF, 1'b1));
    send_item(mk_query(32'd3));
    // Full-width span in the last stage, then clear it again
    send_item(mk_write(NUM_STAGES - 1, 63, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1));
    send_item(mk_query(32'h0));
    send_item(mk_query(32'hFFFF_FFFF));
    send_item(mk_write(NUM_STAGES - 1, 63, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0));

    // Random items through the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      for (int n = 0; n < RAND_ITEMS / 4; n++) send_item(rand_item());
    end
    in_chan.valid <= 1'b0;

    // Drain outstanding results, then watch for stray beats
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d translates (%0d hitting a stage), %0d writes past the table.",
             sent_cnt, xlate_cnt, hit_cnt, dropped_writes);
    $display("Covered four idling phases and a %0d-cycle receiver hold-off in %0d cycles.",
             HOLD_CYCLES, cycle_cnt);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatching results", mismatch_cnt);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
